// ----- design/cdf_pkg.sv -----
`timescale 1ns / 1ps
package cdf_pkg;

    // Defaults of the top level parameters
    localparam int VEC_MAX_DEF   = 32;
    localparam int WIN_MAX_DEF   = 7;
    localparam int ORDER_MAX_DEF = 3;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int COEFF_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ELEM_W     = 5;
    localparam int LEVEL_W    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ORDERS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_GAIN  = 2'd3;

    // Configuration reset values
    localparam logic [2:0]        WINDOW_HALF_RST = 3'd2;
    localparam logic [1:0]        NUM_ORDERS_RST  = 2'd2;
    localparam logic [5:0]        FRAME_LEN_RST   = 6'd13;
    localparam logic [GAIN_W-1:0] DELTA_GAIN_RST  = 16'd6554;

    // Request kinds
    localparam logic REQ_COEFF = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic               hist_we;
        logic               load;
        logic               tap;
        logic               tap_first;
        logic               tap_last;
        logic               emit;
        logic [LEVEL_W-1:0] level;
    } cdf_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } cdf_sts_t;

endpackage

// ----- design/cascaded_delta_features.sv -----
`timescale 1ns / 1ps
// Cascaded regression deltas over a stream of static feature coefficients, sent one
// element per item, frame after frame; a flush item (tuser high) ends the stream and
// releases one pending element per flush. The time of each computing item is set by
// the single multiply-accumulate unit that takes one window tap per cycle and by the
// one read port of the frame history memory while it gathers the window, plus any
// time the output is stalled; items that cause no result leave the block ready for
// the next item. A new item is accepted once the last result of the previous one has
// entered the output register.
module cascaded_delta_features
    import cdf_pkg::*;
#(
    parameter int VEC_MAX   = VEC_MAX_DEF,
    parameter int WIN_MAX   = WIN_MAX_DEF,
    parameter int ORDER_MAX = ORDER_MAX_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int ORDER_EFF = (ORDER_MAX > 3) ? 3 : ORDER_MAX,
    localparam int R_MAX     = ORDER_EFF * WIN_MAX,
    localparam int H         = 2 * ORDER_MAX * WIN_MAX + 1,
    localparam int EW        = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1,
    localparam int FLW       = $clog2(VEC_MAX + 1),
    localparam int IW        = $clog2(WIN_MAX + 1),
    localparam int RW        = $clog2(R_MAX + 1),
    localparam int SW        = $clog2(H),
    localparam int OW        = $clog2(R_MAX + WIN_MAX + 1) + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // [31:0] coeff_value
    input  logic                  s_axis_tuser,   // [0] req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,   // [4:0] elem_index, [6:5] level,
                                                  // [38:7] out_value, [39] zero
    output logic                  m_axis_tlast,   // last_of_run
    output logic                  m_axis_tuser    // [0] last_of_frame
);

    cdf_cmd_t             cmd;
    cdf_sts_t             sts;
    logic [SW-1:0]        wr_slot, center;
    logic [EW-1:0]        wr_elem, elem;
    logic [RW-1:0]        lo_mag, hi_mag, kw;
    logic [LEVEL_W-1:0]   k_eff;
    logic [FLW-1:0]       flen;
    logic [GAIN_W-1:0]    gain;
    logic signed [OW-1:0] step_o;
    logic [IW-1:0]        step_i;
    logic [ELEM_W-1:0]    out_elem_index;
    logic [LEVEL_W-1:0]   out_level;
    logic signed [COEFF_W-1:0] out_value;

    cdf_ctrl #(
        .VEC_MAX   (VEC_MAX),
        .WIN_MAX   (WIN_MAX),
        .ORDER_MAX (ORDER_MAX)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_req_type (s_axis_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .wr_slot     (wr_slot),
        .wr_elem     (wr_elem),
        .center      (center),
        .lo_mag      (lo_mag),
        .hi_mag      (hi_mag),
        .elem        (elem),
        .kw          (kw),
        .k_eff       (k_eff),
        .flen        (flen),
        .gain        (gain),
        .step_o      (step_o),
        .step_i      (step_i)
    );

    cdf_dp #(
        .VEC_MAX   (VEC_MAX),
        .WIN_MAX   (WIN_MAX),
        .ORDER_MAX (ORDER_MAX),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .coeff             (s_axis_tdata),
        .wr_slot           (wr_slot),
        .wr_elem           (wr_elem),
        .center            (center),
        .lo_mag            (lo_mag),
        .hi_mag            (hi_mag),
        .elem              (elem),
        .kw                (kw),
        .k_eff             (k_eff),
        .flen              (flen),
        .gain              (gain),
        .step_o            (step_o),
        .step_i            (step_i),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .out_elem_index    (out_elem_index),
        .out_level         (out_level),
        .out_value         (out_value),
        .out_last_of_run   (m_axis_tlast),
        .out_last_of_frame (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_value, out_level, out_elem_index};

    // The highest level of an element is always a delta level
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[6:5] != 2'd0))
        else $error("last result of an element carries the static level");

    // While lower levels of an element are out, its higher levels are still owed
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input taken before all levels of an element were issued");

    // A flush item never reaches the history memory
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser) |-> !cmd.hist_we)
        else $error("history written by a flush item");

endmodule

// ----- design/cdf_ram.sv -----
`timescale 1ns / 1ps
module cdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/cdf_ctrl.sv -----
`timescale 1ns / 1ps
module cdf_ctrl
    import cdf_pkg::*;
#(
    parameter int VEC_MAX   = VEC_MAX_DEF,
    parameter int WIN_MAX   = WIN_MAX_DEF,
    parameter int ORDER_MAX = ORDER_MAX_DEF,
    localparam int ORDER_EFF = (ORDER_MAX > 3) ? 3 : ORDER_MAX,
    localparam int R_MAX     = ORDER_EFF * WIN_MAX,
    localparam int H         = 2 * ORDER_MAX * WIN_MAX + 1,
    localparam int EW        = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1,
    localparam int FLW       = $clog2(VEC_MAX + 1),
    localparam int IW        = $clog2(WIN_MAX + 1),
    localparam int RW        = $clog2(R_MAX + 1),
    localparam int SW        = $clog2(H),
    localparam int OW        = $clog2(R_MAX + WIN_MAX + 1) + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input handshake
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_req_type,
    // datapath control
    output cdf_cmd_t              cmd,
    input  cdf_sts_t              sts,
    output logic [SW-1:0]         wr_slot,
    output logic [EW-1:0]         wr_elem,
    output logic [SW-1:0]         center,
    output logic [RW-1:0]         lo_mag,
    output logic [RW-1:0]         hi_mag,
    output logic [EW-1:0]         elem,
    output logic [RW-1:0]         kw,
    output logic [LEVEL_W-1:0]    k_eff,
    output logic [FLW-1:0]        flen,
    output logic [GAIN_W-1:0]     gain,
    output logic signed [OW-1:0]  step_o,
    output logic [IW-1:0]         step_i
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOAD    = 3'd1;
    localparam logic [2:0] ST_LDRAIN  = 3'd2;
    localparam logic [2:0] ST_LEVEL   = 3'd3;
    localparam logic [2:0] ST_LVDRAIN = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;

    logic [2:0]        win_reg;
    logic [1:0]        ord_reg;
    logic [5:0]        flen_reg;
    logic [GAIN_W-1:0] gain_reg;

    logic [2:0]         state_reg, state_next;
    logic [SW-1:0]      wslot_reg, wslot_next;
    logic [EW-1:0]      ecnt_reg, ecnt_next;
    logic [31:0]        fin_reg, fin_next;
    logic [RW-1:0]      fout_reg, fout_next;
    logic               ended_reg, ended_next;
    logic [EW-1:0]      e_reg, e_next;
    logic [SW-1:0]      center_reg, center_next;
    logic [RW-1:0]      lo_reg, lo_next;
    logic [RW-1:0]      hi_reg, hi_next;
    logic signed [OW-1:0] o_reg, o_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [LEVEL_W-1:0] k_reg, k_next;
    logic [RW-1:0]      r_reg, r_next;
    logic [1:0]         dcnt_reg, dcnt_next;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;

    logic [IW-1:0]  w_eff;
    logic [EW-1:0]  e_cur;
    logic [EW-1:0]  e2;
    logic [RW-1:0]  fo_a;
    logic [31:0]    older;
    logic           e_cur_last;
    logic           e2_last;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= WINDOW_HALF_RST;
            ord_reg  <= NUM_ORDERS_RST;
            flen_reg <= FRAME_LEN_RST;
            gain_reg <= DELTA_GAIN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WINDOW_HALF: win_reg  <= cfg_data[2:0];
                REG_NUM_ORDERS:  ord_reg  <= cfg_data[1:0];
                REG_FRAME_LEN:   flen_reg <= cfg_data[5:0];
                REG_DELTA_GAIN:  gain_reg <= cfg_data[GAIN_W-1:0];
                default:         win_reg  <= win_reg;
            endcase
        end
    end

    // Effective (limited) settings
    always_comb
    begin
        if (win_reg == 3'd0)
            w_eff = IW'(1);
        else if (32'(win_reg) > WIN_MAX)
            w_eff = IW'(WIN_MAX);
        else
            w_eff = IW'(win_reg);

        if (ord_reg == 2'd0)
            k_eff = LEVEL_W'(1);
        else if (32'(ord_reg) > ORDER_EFF)
            k_eff = LEVEL_W'(ORDER_EFF);
        else
            k_eff = ord_reg;

        if (flen_reg == 6'd0)
            flen = FLW'(1);
        else if (32'(flen_reg) > VEC_MAX)
            flen = FLW'(VEC_MAX);
        else
            flen = FLW'(flen_reg);
    end

    assign kw   = RW'(32'(k_eff) * 32'(w_eff));
    assign gain = gain_reg;

    // Element cursor, a cursor past the frame acts as the last element
    assign e_cur = (32'(ecnt_reg) >= 32'(flen)) ? EW'(32'(flen) - 32'd1) : ecnt_reg;
    assign e_cur_last = (32'(e_cur) + 32'd1 >= 32'(flen));

    assign wr_slot = wslot_reg;
    assign wr_elem = e_cur;
    assign center  = center_reg;
    assign lo_mag  = lo_reg;
    assign hi_mag  = hi_reg;
    assign elem    = e_reg;
    assign step_o  = o_reg;
    assign step_i  = i_reg;
    assign in_ready = (state_reg == ST_IDLE);

    // Flush bookkeeping values
    always_comb
    begin
        if (!ended_reg)
        begin
            if (fin_reg >= 32'(kw))
            begin
                fo_a = kw;
                e2   = e_cur;
            end
            else
            begin
                fo_a = RW'(fin_reg);
                e2   = '0;
            end
        end
        else
        begin
            fo_a = fout_reg;
            e2   = e_cur;
        end
        e2_last = (32'(e2) + 32'd1 >= 32'(flen));
        older   = (fin_reg >= 32'(fo_a)) ? fin_reg - 32'(fo_a) : 32'd0;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        wslot_next  = wslot_reg;
        ecnt_next   = ecnt_reg;
        fin_next    = fin_reg;
        fout_next   = fout_reg;
        ended_next  = ended_reg;
        e_next      = e_reg;
        center_next = center_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        o_next      = o_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        r_next      = r_reg;
        dcnt_next   = dcnt_reg;
        lvl_next    = lvl_reg;
        cmd         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_req_type == REQ_COEFF)
                    begin
                        if (!ended_reg)
                        begin
                            cmd.hist_we = 1'b1;
                            if (fin_reg >= 32'(kw))
                            begin
                                e_next      = e_cur;
                                center_next = (wslot_reg >= SW'(kw)) ?
                                              SW'(32'(wslot_reg) - 32'(kw)) :
                                              SW'(32'(wslot_reg) + H - 32'(kw));
                                lo_next     = ((fin_reg - 32'(kw)) > 32'(kw)) ?
                                              kw : RW'(fin_reg - 32'(kw));
                                hi_next     = kw;
                                o_next      = -$signed(OW'(kw));
                                state_next  = ST_LOAD;
                            end
                            if (e_cur_last)
                            begin
                                ecnt_next  = '0;
                                wslot_next = (32'(wslot_reg) == H - 1) ? '0 :
                                             SW'(32'(wslot_reg) + 32'd1);
                                if (fin_reg != '1)
                                    fin_next = fin_reg + 32'd1;
                            end
                            else
                            begin
                                ecnt_next = EW'(32'(e_cur) + 32'd1);
                            end
                        end
                    end
                    else
                    begin
                        ended_next = 1'b1;
                        fout_next  = fo_a;
                        if (!ended_reg)
                            ecnt_next = e2;
                        if (fo_a != '0)
                        begin
                            e_next      = e2;
                            center_next = (wslot_reg >= SW'(fo_a)) ?
                                          SW'(32'(wslot_reg) - 32'(fo_a)) :
                                          SW'(32'(wslot_reg) + H - 32'(fo_a));
                            lo_next     = (older > 32'(kw)) ? kw : RW'(older);
                            hi_next     = ((fo_a - RW'(1)) > kw) ? kw : fo_a - RW'(1);
                            o_next      = -$signed(OW'(kw));
                            state_next  = ST_LOAD;
                            if (e2_last)
                            begin
                                ecnt_next = '0;
                                fout_next = fo_a - RW'(1);
                            end
                            else
                            begin
                                ecnt_next = EW'(32'(e2) + 32'd1);
                            end
                        end
                    end
                end
            end

            // Gather the window of static values
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                if (o_reg == $signed(OW'(kw)))
                    state_next = ST_LDRAIN;
                else
                    o_next = o_reg + OW'(1);
            end

            ST_LDRAIN:
            begin
                k_next     = LEVEL_W'(1);
                r_next     = RW'(32'(k_eff - LEVEL_W'(1)) * 32'(w_eff));
                o_next     = -$signed(OW'(RW'(32'(k_eff - LEVEL_W'(1)) * 32'(w_eff))));
                i_next     = IW'(1);
                state_next = ST_LEVEL;
            end

            // One tap of the regression sum per cycle
            ST_LEVEL:
            begin
                cmd.tap       = 1'b1;
                cmd.tap_first = (i_reg == IW'(1));
                cmd.tap_last  = (i_reg == w_eff);
                cmd.level     = k_reg;
                if (i_reg == w_eff)
                begin
                    i_next = IW'(1);
                    if (o_reg == $signed(OW'(r_reg)))
                    begin
                        dcnt_next  = '0;
                        state_next = ST_LVDRAIN;
                    end
                    else
                    begin
                        o_next = o_reg + OW'(1);
                    end
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                end
            end

            // Let the multiply and write-back finish
            ST_LVDRAIN:
            begin
                dcnt_next = dcnt_reg + 2'd1;
                if (dcnt_reg == 2'd2)
                begin
                    if (k_reg == k_eff)
                    begin
                        lvl_next   = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        k_next     = k_reg + LEVEL_W'(1);
                        r_next     = RW'(32'(k_eff - k_reg - LEVEL_W'(1)) * 32'(w_eff));
                        o_next     = -$signed(OW'(RW'(32'(k_eff - k_reg - LEVEL_W'(1)) *
                                                       32'(w_eff))));
                        i_next     = IW'(1);
                        state_next = ST_LEVEL;
                    end
                end
            end

            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit  = 1'b1;
                    cmd.level = lvl_reg;
                    if (lvl_reg == k_eff)
                        state_next = ST_IDLE;
                    else
                        lvl_next = lvl_reg + LEVEL_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wslot_reg <= '0;
            ecnt_reg  <= '0;
            fin_reg   <= '0;
            fout_reg  <= '0;
            ended_reg <= 1'b0;
            o_reg     <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
            dcnt_reg  <= '0;
            lvl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wslot_reg <= wslot_next;
            ecnt_reg  <= ecnt_next;
            fin_reg   <= fin_next;
            fout_reg  <= fout_next;
            ended_reg <= ended_next;
            o_reg     <= o_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
            dcnt_reg  <= dcnt_next;
            lvl_reg   <= lvl_next;
        end
    end

    // Per-item parameters
    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        center_reg <= center_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
    end

endmodule

// ----- design/cdf_dp.sv -----
`timescale 1ns / 1ps
module cdf_dp
    import cdf_pkg::*;
#(
    parameter int VEC_MAX   = VEC_MAX_DEF,
    parameter int WIN_MAX   = WIN_MAX_DEF,
    parameter int ORDER_MAX = ORDER_MAX_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int ORDER_EFF = (ORDER_MAX > 3) ? 3 : ORDER_MAX,
    localparam int R_MAX     = ORDER_EFF * WIN_MAX,
    localparam int H         = 2 * ORDER_MAX * WIN_MAX + 1,
    localparam int HD        = H * VEC_MAX,
    localparam int HAW       = (HD > 1) ? $clog2(HD) : 1,
    localparam int WD        = 2 * R_MAX + 1,
    localparam int WJ        = (WD > 1) ? $clog2(WD) : 1,
    localparam int EW        = (VEC_MAX > 1) ? $clog2(VEC_MAX) : 1,
    localparam int FLW       = $clog2(VEC_MAX + 1),
    localparam int IW        = $clog2(WIN_MAX + 1),
    localparam int RW        = $clog2(R_MAX + 1),
    localparam int SW        = $clog2(H),
    localparam int OW        = $clog2(R_MAX + WIN_MAX + 1) + 1,
    localparam int SSW       = ((SW > OW) ? SW : OW) + 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cdf_cmd_t                    cmd,
    output cdf_sts_t                    sts,
    input  logic signed [COEFF_W-1:0]   coeff,
    input  logic [SW-1:0]               wr_slot,
    input  logic [EW-1:0]               wr_elem,
    input  logic [SW-1:0]               center,
    input  logic [RW-1:0]               lo_mag,
    input  logic [RW-1:0]               hi_mag,
    input  logic [EW-1:0]               elem,
    input  logic [RW-1:0]               kw,
    input  logic [LEVEL_W-1:0]          k_eff,
    input  logic [FLW-1:0]              flen,
    input  logic [GAIN_W-1:0]           gain,
    input  logic signed [OW-1:0]        step_o,
    input  logic [IW-1:0]               step_i,
    // result register
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ELEM_W-1:0]           out_elem_index,
    output logic [LEVEL_W-1:0]          out_level,
    output logic signed [COEFF_W-1:0]   out_value,
    output logic                        out_last_of_run,
    output logic                        out_last_of_frame
);

    logic signed [OW-1:0] lo_s, hi_s, rr_s;
    logic signed [OW-1:0] oc, pp, mm;
    logic signed [SSW-1:0] slot_raw;
    logic [SW-1:0]        slot;
    logic [HAW-1:0]       hist_waddr, hist_raddr;
    logic [COEFF_W-1:0]   hist_rdata;
    logic [WJ-1:0]        pp_addr, mm_addr;

    logic [COEFF_W-1:0]   rd_a0, rd_a1, rd_b0, rd_b1;
    logic [COEFF_W-1:0]   plus_v, minus_v, tap_term;
    logic                 we0, we1;
    logic [WJ-1:0]        wk_addr;
    logic [COEFF_W-1:0]   wk_data;
    logic [COEFF_W-1:0]   lvl_val;
    logic signed [COEFF_W+GAIN_W:0] prod_shift;

    // pipeline control
    logic                 load_d1, tap_d1, first_d1, last_d1, src_d1;
    logic                 last_d2, last_d3;
    logic signed [OW-1:0] o_d1, o_d2, o_d3;
    logic [IW-1:0]        i_d1;
    logic [LEVEL_W-1:0]   k_d2, k_d3;
    logic [LEVEL_W-1:0]   k_d1;
    logic [COEFF_W-1:0]   acc_reg;
    logic signed [COEFF_W+GAIN_W:0] prod_reg;
    logic [COEFF_W-1:0]   res_reg [0:3];
    logic                 out_valid_reg;

    // Window bounds as signed offsets
    assign lo_s = -$signed(OW'(lo_mag));
    assign hi_s = $signed(OW'(hi_mag));
    assign rr_s = $signed(OW'(kw));

    // Edge replication of frame offsets
    always_comb
    begin
        if (step_o < lo_s)
            oc = lo_s;
        else if (step_o > hi_s)
            oc = hi_s;
        else
            oc = step_o;

        pp = step_o + $signed(OW'(step_i));
        if (pp < lo_s)
            pp = lo_s;
        else if (pp > hi_s)
            pp = hi_s;

        mm = step_o - $signed(OW'(step_i));
        if (mm < lo_s)
            mm = lo_s;
        else if (mm > hi_s)
            mm = hi_s;
    end

    // Ring slot of the offset frame
    always_comb
    begin
        slot_raw = $signed(SSW'(center)) + SSW'(oc);
        if (slot_raw < 0)
            slot = SW'(slot_raw + SSW'(H));
        else if (slot_raw >= SSW'(H))
            slot = SW'(slot_raw - SSW'(H));
        else
            slot = SW'(slot_raw);
    end

    assign hist_waddr = HAW'(32'(wr_slot) * VEC_MAX + 32'(wr_elem));
    assign hist_raddr = HAW'(32'(slot) * VEC_MAX + 32'(elem));
    assign pp_addr    = WJ'(pp + rr_s);
    assign mm_addr    = WJ'(mm + rr_s);

    cdf_ram #(.WIDTH(COEFF_W), .DEPTH(HD)) u_hist (
        .clk   (clk),
        .we    (cmd.hist_we),
        .waddr (hist_waddr),
        .wdata (coeff),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // Ping-pong level buffers, two copies each for two read addresses
    assign we0      = load_d1 | (last_d3 & ~k_d3[0]);
    assign we1      = last_d3 & k_d3[0];
    assign lvl_val  = prod_shift[COEFF_W-1:0];
    assign wk_addr  = load_d1 ? WJ'(o_d1 + rr_s) : WJ'(o_d3 + rr_s);
    assign wk_data  = load_d1 ? hist_rdata : lvl_val;

    cdf_ram #(.WIDTH(COEFF_W), .DEPTH(WD)) u_buf_a0 (
        .clk(clk), .we(we0), .waddr(wk_addr), .wdata(wk_data), .raddr(pp_addr), .rdata(rd_a0)
    );
    cdf_ram #(.WIDTH(COEFF_W), .DEPTH(WD)) u_buf_a1 (
        .clk(clk), .we(we0), .waddr(wk_addr), .wdata(wk_data), .raddr(mm_addr), .rdata(rd_a1)
    );
    cdf_ram #(.WIDTH(COEFF_W), .DEPTH(WD)) u_buf_b0 (
        .clk(clk), .we(we1), .waddr(wk_addr), .wdata(wk_data), .raddr(pp_addr), .rdata(rd_b0)
    );
    cdf_ram #(.WIDTH(COEFF_W), .DEPTH(WD)) u_buf_b1 (
        .clk(clk), .we(we1), .waddr(wk_addr), .wdata(wk_data), .raddr(mm_addr), .rdata(rd_b1)
    );

    // Weighted difference of one tap
    assign plus_v   = src_d1 ? rd_b0 : rd_a0;
    assign minus_v  = src_d1 ? rd_b1 : rd_a1;
    assign tap_term = COEFF_W'((plus_v - minus_v) * COEFF_W'(i_d1));

    // Gain multiply, floor shift falls out of the arithmetic shift
    assign prod_shift = prod_reg >>> FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_d1       <= 1'b0;
            tap_d1        <= 1'b0;
            last_d2       <= 1'b0;
            last_d3       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            load_d1 <= cmd.load;
            tap_d1  <= cmd.tap;
            last_d2 <= tap_d1 & last_d1;
            last_d3 <= last_d2;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        o_d1     <= step_o;
        i_d1     <= step_i;
        first_d1 <= cmd.tap_first;
        last_d1  <= cmd.tap_last;
        src_d1   <= ~cmd.level[0];
        k_d1     <= cmd.level;
        o_d2     <= o_d1;
        k_d2     <= k_d1;
        o_d3     <= o_d2;
        k_d3     <= k_d2;

        if (tap_d1)
            acc_reg <= (first_d1 ? '0 : acc_reg) + tap_term;
        if (last_d2)
            prod_reg <= $signed(acc_reg) * $signed({1'b0, gain});

        // center values of each level
        if (load_d1 && o_d1 == '0)
            res_reg[0] <= hist_rdata;
        if (last_d3 && o_d3 == '0)
            res_reg[k_d3] <= lvl_val;

        if (cmd.emit)
        begin
            out_elem_index    <= ELEM_W'(elem);
            out_level         <= cmd.level;
            out_value         <= res_reg[cmd.level];
            out_last_of_run   <= (cmd.level == k_eff);
            out_last_of_frame <= (32'(elem) + 32'd1 == 32'(flen));
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.out_free = ~out_valid_reg | out_ready;

endmodule
